// ===== design/pbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared types and constants of the plane border padding block: plane
// geometry, pad limits, mode and status codes, register map.
// ----------------------------------------------------------------------------
package pbp_pkg;

	// plane geometry
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_PAD    = 32;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int STORE_DEPTH = MAX_HEIGHT * MAX_WIDTH;
	localparam int PIX_W      = 32;

	// signed width for all index arithmetic
	localparam int SW = 9;

	// register map
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam logic [2:0] REG_IN_HEIGHT  = 3'd0;
	localparam logic [2:0] REG_IN_WIDTH   = 3'd1;
	localparam logic [2:0] REG_PAD_TOP    = 3'd2;
	localparam logic [2:0] REG_PAD_BOTTOM = 3'd3;
	localparam logic [2:0] REG_PAD_LEFT   = 3'd4;
	localparam logic [2:0] REG_PAD_RIGHT  = 3'd5;
	localparam logic [2:0] REG_PAD_MODE   = 3'd6;
	localparam logic [2:0] REG_FILL_WORD  = 3'd7;

	// pad modes
	localparam logic [1:0] MODE_CONST = 2'd0;
	localparam logic [1:0] MODE_REPL  = 2'd1;
	localparam logic [1:0] MODE_REFL  = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	// commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// result status
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_RANGE  = 2'd1,
		ST_CONFIG = 2'd2
	} pbp_status_t;

	// one axis of the output-to-input mapping
	typedef struct packed {
		logic                 hit;
		logic signed [SW-1:0] src;
	} axis_map_t;

endpackage

// ===== design/pbp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_in_if
// Command channel: load or read beats with row, column and pixel word.
// ----------------------------------------------------------------------------
interface pbp_in_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [6:0]                    row;
	logic [6:0]                    col;
	logic [pbp_pkg::PIX_W-1:0]     pixel_in;

	modport source (output valid, command, row, col, pixel_in, input ready);
	modport sink   (input valid, command, row, col, pixel_in, output ready);
endinterface

// ===== design/pbp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_out_if
// Result channel: padded pixel word and status per read beat.
// ----------------------------------------------------------------------------
interface pbp_out_if;
	logic                          valid;
	logic                          ready;
	logic [pbp_pkg::PIX_W-1:0]     pixel_out;
	logic [1:0]                    status;

	modport source (output valid, pixel_out, status, input ready);
	modport sink   (input valid, pixel_out, status, output ready);
endinterface

// ===== design/plane_border_pad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_border_pad
// Border padding of one stored image plane: loads fill the plane store,
// reads return the constant, replicate or reflect padded (or cropped) pixel.
// ----------------------------------------------------------------------------
// Pipeline: a read beat passes the plane store read register and then the
// output register before its result is presented.
// Throughput: one beat per cycle, load or read, unless the result channel
// stalls; set by the single read and single write port of the plane store.
// Reset: registers return to in_height = in_width = 1, all else 0; the plane
// store is not cleared and holds no valid data until loaded.
module plane_border_pad (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pbp_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [pbp_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pbp_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	pbp_in_if.sink                           req_ch,
	pbp_out_if.source                        rsp_ch
);

	localparam int SW    = pbp_pkg::SW;
	localparam int ROW_W = pbp_pkg::ROW_W;
	localparam int COL_W = pbp_pkg::COL_W;
	localparam int ADDR_W = ROW_W + COL_W;

	// configuration registers
	logic [6:0]                in_height_q;
	logic [6:0]                in_width_q;
	logic [6:0]                pad_top_q;
	logic [6:0]                pad_bottom_q;
	logic [6:0]                pad_left_q;
	logic [6:0]                pad_right_q;
	logic [1:0]                pad_mode_q;
	logic [pbp_pkg::PIX_W-1:0] fill_word_q;

	// mapping
	logic [6:0]           h_e;
	logic [6:0]           w_e;
	logic signed [SW-1:0] h_s, w_s, pt, pb, pl, pr, oh, ow, r_s, c_s;
	logic                 all_neg, any_neg;
	pbp_pkg::axis_map_t   map_r, map_c;
	pbp_pkg::pbp_status_t rd_status;
	logic                 rd_fill;
	logic signed [SW-1:0] src_r, src_c;

	// handshake and pipeline
	logic                 acc;
	logic                 acc_rd;
	logic                 acc_ld;
	logic                 out_free;
	logic                 s1_adv;
	logic                 ld_ok;
	logic                 rd_valid_s1;
	pbp_pkg::pbp_status_t rd_status_s1;
	logic                 rd_fill_s1;
	logic                 out_valid_q;
	logic [pbp_pkg::PIX_W-1:0] out_pixel_q;
	logic [1:0]           out_status_q;
	logic [pbp_pkg::PIX_W-1:0] ram_rdata;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;
	logic                 cfg_we;

	function automatic logic [6:0] eff_size(input logic [6:0] v, input int max);
		logic [6:0] r;
		if (v == 7'd0) begin
			r = 7'd1;
		end else if (v > 7'(max)) begin
			r = 7'(max);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic signed [SW-1:0] eff_pad(input logic [6:0] v);
		logic signed [SW-1:0] e;
		logic signed [SW-1:0] lim;
		e   = signed'({{(SW-7){v[6]}}, v});
		lim = SW'(pbp_pkg::MAX_PAD);
		if (e > lim) begin
			e = lim;
		end else if (e < -lim) begin
			e = -lim;
		end
		return e;
	endfunction

	function automatic pbp_pkg::axis_map_t map_axis(
		input logic signed [SW-1:0] pos,
		input logic signed [SW-1:0] lead,
		input logic signed [SW-1:0] size,
		input logic [1:0]           mode
	);
		logic signed [SW-1:0] y;
		pbp_pkg::axis_map_t   m;
		y     = pos - lead;
		m.hit = 1'b1;
		m.src = y;
		if (y >= SW'(0) && y < size) begin
			m.src = y;
		end else if (mode == pbp_pkg::MODE_CONST) begin
			m.hit = 1'b0;
			m.src = '0;
		end else if (mode == pbp_pkg::MODE_REPL) begin
			m.src = (y < SW'(0)) ? SW'(0) : size - SW'(1);
		end else begin
			m.src = (y < SW'(0)) ? -y : ((size - SW'(1)) <<< 1) - y;
		end
		return m;
	endfunction

	// apb write decode
	assign cfg_we = psel & penable & pwrite & pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q  <= 7'd1;
			in_width_q   <= 7'd1;
			pad_top_q    <= '0;
			pad_bottom_q <= '0;
			pad_left_q   <= '0;
			pad_right_q  <= '0;
			pad_mode_q   <= pbp_pkg::MODE_CONST;
			fill_word_q  <= '0;
		end else if (cfg_we) begin
			case (paddr[4:2])
				pbp_pkg::REG_IN_HEIGHT:  in_height_q  <= pwdata[6:0];
				pbp_pkg::REG_IN_WIDTH:   in_width_q   <= pwdata[6:0];
				pbp_pkg::REG_PAD_TOP:    pad_top_q    <= pwdata[6:0];
				pbp_pkg::REG_PAD_BOTTOM: pad_bottom_q <= pwdata[6:0];
				pbp_pkg::REG_PAD_LEFT:   pad_left_q   <= pwdata[6:0];
				pbp_pkg::REG_PAD_RIGHT:  pad_right_q  <= pwdata[6:0];
				pbp_pkg::REG_PAD_MODE:   pad_mode_q   <= pwdata[1:0];
				pbp_pkg::REG_FILL_WORD:  fill_word_q  <= pwdata;
				default: ;
			endcase
		end
	end

	// apb read mux
	always_comb begin
		prdata = '0;
		case (paddr[4:2])
			pbp_pkg::REG_IN_HEIGHT:  prdata = {25'd0, in_height_q};
			pbp_pkg::REG_IN_WIDTH:   prdata = {25'd0, in_width_q};
			pbp_pkg::REG_PAD_TOP:    prdata = {25'd0, pad_top_q};
			pbp_pkg::REG_PAD_BOTTOM: prdata = {25'd0, pad_bottom_q};
			pbp_pkg::REG_PAD_LEFT:   prdata = {25'd0, pad_left_q};
			pbp_pkg::REG_PAD_RIGHT:  prdata = {25'd0, pad_right_q};
			pbp_pkg::REG_PAD_MODE:   prdata = {30'd0, pad_mode_q};
			pbp_pkg::REG_FILL_WORD:  prdata = fill_word_q;
			default:                 prdata = '0;
		endcase
	end

	// effective geometry
	assign h_e = eff_size(in_height_q, pbp_pkg::MAX_HEIGHT);
	assign w_e = eff_size(in_width_q, pbp_pkg::MAX_WIDTH);
	assign h_s = signed'({{(SW-7){1'b0}}, h_e});
	assign w_s = signed'({{(SW-7){1'b0}}, w_e});
	assign pt  = eff_pad(pad_top_q);
	assign pb  = eff_pad(pad_bottom_q);
	assign pl  = eff_pad(pad_left_q);
	assign pr  = eff_pad(pad_right_q);
	assign oh  = h_s + pt + pb;
	assign ow  = w_s + pl + pr;
	assign r_s = signed'({{(SW-7){1'b0}}, req_ch.row});
	assign c_s = signed'({{(SW-7){1'b0}}, req_ch.col});
	assign all_neg = pt[SW-1] & pb[SW-1] & pl[SW-1] & pr[SW-1];
	assign any_neg = pt[SW-1] | pb[SW-1] | pl[SW-1] | pr[SW-1];
	assign map_r = map_axis(r_s, pt, h_s, pad_mode_q);
	assign map_c = map_axis(c_s, pl, w_s, pad_mode_q);

	// read classification and source position
	always_comb begin
		rd_status = pbp_pkg::ST_OK;
		rd_fill   = 1'b0;
		src_r     = map_r.src;
		src_c     = map_c.src;
		if (pad_mode_q == pbp_pkg::MODE_RSVD) begin
			rd_status = pbp_pkg::ST_CONFIG;
		end else if (all_neg) begin
			src_r = r_s - pt;
			src_c = c_s - pl;
			if (oh <= SW'(0) || ow <= SW'(0)) begin
				rd_status = pbp_pkg::ST_CONFIG;
			end else if (r_s >= oh || c_s >= ow) begin
				rd_status = pbp_pkg::ST_RANGE;
			end
		end else if (any_neg) begin
			rd_status = pbp_pkg::ST_CONFIG;
		end else if (pad_mode_q == pbp_pkg::MODE_REFL &&
				(pt >= h_s || pb >= h_s || pl >= w_s || pr >= w_s)) begin
			rd_status = pbp_pkg::ST_CONFIG;
		end else if (r_s >= oh || c_s >= ow) begin
			rd_status = pbp_pkg::ST_RANGE;
		end else begin
			rd_fill = ~(map_r.hit & map_c.hit);
		end
	end

	// handshake
	assign out_free     = ~out_valid_q | rsp_ch.ready;
	assign s1_adv       = rd_valid_s1 & out_free;
	assign req_ch.ready = ~rd_valid_s1 | out_free;
	assign acc          = req_ch.valid & req_ch.ready;
	assign acc_rd       = acc & (req_ch.command == pbp_pkg::CMD_READ);
	assign acc_ld       = acc & (req_ch.command == pbp_pkg::CMD_LOAD);
	assign ld_ok        = ({1'b0, req_ch.row} < {1'b0, h_e}) &
	                      ({1'b0, req_ch.col} < {1'b0, w_e});

	// store addresses
	assign waddr = {req_ch.row[ROW_W-1:0], req_ch.col[COL_W-1:0]};
	assign raddr = {src_r[ROW_W-1:0], src_c[COL_W-1:0]};

	// plane store
	pbp_ram #(
		.WIDTH (pbp_pkg::PIX_W),
		.DEPTH (pbp_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (acc_ld & ld_ok),
		.waddr (waddr),
		.wdata (req_ch.pixel_in),
		.re    (acc_rd),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// read stage: waits on the store read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else if (req_ch.ready) begin
			rd_valid_s1 <= acc_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_rd) begin
			rd_status_s1 <= rd_status;
			rd_fill_s1   <= rd_fill;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_status_q <= rd_status_s1;
			if (rd_status_s1 != pbp_pkg::ST_OK) begin
				out_pixel_q <= '0;
			end else if (rd_fill_s1) begin
				out_pixel_q <= fill_word_q;
			end else begin
				out_pixel_q <= ram_rdata;
			end
		end
	end

	assign rsp_ch.valid     = out_valid_q;
	assign rsp_ch.pixel_out = out_pixel_q;
	assign rsp_ch.status    = out_status_q;

endmodule

// ===== design/pbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pbp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for plane_border_pad. Loads and reads are queued
// phase by phase, each under its own register setting programmed over APB
// while the block is idle. A built-in padding predictor works out every
// read result, and the monitor compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb;
	import pbp_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 1850;
	localparam int SETTLE       = 4;

	// one command beat and one result beat
	typedef struct {
		logic             command;
		logic [6:0]       row;
		logic [6:0]       col;
		logic [PIX_W-1:0] pixel;
	} pad_cmd_t;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		pbp_status_t      status;
	} pad_result_t;

	// register image
	typedef struct {
		logic [6:0]       height;
		logic [6:0]       width;
		logic [6:0]       top;
		logic [6:0]       bottom;
		logic [6:0]       left;
		logic [6:0]       right;
		logic [1:0]       mode;
		logic [PIX_W-1:0] fill;
	} pad_cfg_t;

	// receiver stall styles
	typedef enum logic [1:0] {
		RX_FREE, RX_COIN, RX_SPARSE, RX_LONG
	} rx_style_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	pbp_in_if  req_if ();
	pbp_out_if rsp_if ();

	plane_border_pad u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req_ch  (req_if),
		.rsp_ch  (rsp_if)
	);

	// predictor state and bookkeeping
	pad_cfg_t         cfg;
	logic [PIX_W-1:0] plane_img [STORE_DEPTH];
	bit               plane_loaded [STORE_DEPTH];
	pad_cmd_t         cmd_backlog [$];
	pad_result_t      padded_pixels [$];
	int               fault_count;
	int               counted_items;
	int               cycle_count;

	pad_cmd_t         next_beat;
	int               burst_left;
	int               gap_left;
	rx_style_t        rx_style;
	int               rx_left;

	pbp_status_t      seen_status;
	bit               seen_from_store;
	int               seen_idx;
	pad_result_t      want;
	pad_result_t      oldest;

	function automatic int eff_size(input logic [6:0] v, input int maxv);
		if (v == 0)
			return 1;
		if (int'(v) > maxv)
			return maxv;
		return int'(v);
	endfunction

	function automatic int sat_pad(input logic [6:0] v);
		int p;
		p = int'($signed(v));
		if (p > MAX_PAD)
			p = MAX_PAD;
		if (p < -MAX_PAD)
			p = -MAX_PAD;
		return p;
	endfunction

	// one axis: output position to input position, 0 when in constant border
	function automatic bit fold_axis(input int pos, input int lead, input int size,
			input logic [1:0] mode, output int src);
		int y;
		y = pos - lead;
		src = 0;
		if (y >= 0 && y < size) begin
			src = y;
			return 1'b1;
		end
		if (mode == MODE_CONST)
			return 1'b0;
		if (mode == MODE_REPL)
			src = (y < 0) ? 0 : size - 1;
		else
			src = (y < 0) ? -y : 2 * (size - 1) - y;
		return 1'b1;
	endfunction

	// status of a read and, where it comes from the plane, the entry it hits
	function automatic void pad_lookup(input int r, input int c, output pbp_status_t st,
			output bit from_store, output int idx);
		int h, w, pt, pb, pl, pr, oh, ow, sr, sc;
		bit hit_r, hit_c;
		h  = eff_size(cfg.height, MAX_HEIGHT);
		w  = eff_size(cfg.width, MAX_WIDTH);
		pt = sat_pad(cfg.top);
		pb = sat_pad(cfg.bottom);
		pl = sat_pad(cfg.left);
		pr = sat_pad(cfg.right);
		oh = h + pt + pb;
		ow = w + pl + pr;
		st = ST_OK;
		from_store = 1'b0;
		idx = 0;
		if (cfg.mode == MODE_RSVD) begin
			st = ST_CONFIG;
		end else if (pt < 0 && pb < 0 && pl < 0 && pr < 0) begin
			// crop: offset window into the plane
			if (oh <= 0 || ow <= 0)
				st = ST_CONFIG;
			else if (r >= oh || c >= ow)
				st = ST_RANGE;
			else begin
				from_store = 1'b1;
				idx = (r - pt) * MAX_WIDTH + (c - pl);
			end
		end else if (pt < 0 || pb < 0 || pl < 0 || pr < 0) begin
			st = ST_CONFIG;
		end else if (cfg.mode == MODE_REFL && (pt >= h || pb >= h || pl >= w || pr >= w)) begin
			st = ST_CONFIG;
		end else if (r >= oh || c >= ow) begin
			st = ST_RANGE;
		end else begin
			hit_r = fold_axis(r, pt, h, cfg.mode, sr);
			hit_c = fold_axis(c, pl, w, cfg.mode, sc);
			if (hit_r && hit_c) begin
				from_store = 1'b1;
				idx = sr * MAX_WIDTH + sc;
			end
		end
	endfunction

	function automatic pad_cfg_t mk_cfg(input logic [6:0] h, input logic [6:0] w,
			input logic [6:0] t, input logic [6:0] b, input logic [6:0] l,
			input logic [6:0] r, input logic [1:0] m, input logic [PIX_W-1:0] f);
		pad_cfg_t c;
		c.height = h;
		c.width  = w;
		c.top    = t;
		c.bottom = b;
		c.left   = l;
		c.right  = r;
		c.mode   = m;
		c.fill   = f;
		return c;
	endfunction

	function automatic int draw_size();
		return ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
	endfunction

	// mostly thin borders, now and then wide ones
	function automatic int draw_pad(input int hi);
		if (hi <= 0)
			return 0;
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, hi)
			: $urandom_range(0, (hi < 3) ? hi : 3);
	endfunction

	function automatic void flag_error(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endfunction

	// queueing of beats; reads of unloaded entries get a load first
	function automatic void put_load(input int r, input int c, input logic [PIX_W-1:0] p);
		pad_cmd_t b;
		b.command = CMD_LOAD;
		b.row     = 7'(r);
		b.col     = 7'(c);
		b.pixel   = p;
		if (r < eff_size(cfg.height, MAX_HEIGHT) && c < eff_size(cfg.width, MAX_WIDTH)) begin
			plane_loaded[r * MAX_WIDTH + c] = 1'b1;
			counted_items++;
		end
		cmd_backlog.push_back(b);
	endfunction

	function automatic void put_read(input int r, input int c);
		pad_cmd_t b;
		pbp_status_t st;
		bit fs;
		int idx;
		pad_lookup(r, c, st, fs, idx);
		if (st == ST_OK && fs && !plane_loaded[idx])
			put_load(idx / MAX_WIDTH, idx % MAX_WIDTH, $urandom);
		b.command = CMD_READ;
		b.row     = 7'(r);
		b.col     = 7'(c);
		b.pixel   = $urandom;
		counted_items++;
		cmd_backlog.push_back(b);
	endfunction

	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || padded_pixels.size() != 0 || req_if.valid)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// apb write: setup cycle, access cycle
	task automatic write_reg(input logic [2:0] idx, input logic [APB_DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_IN_HEIGHT:  cfg.height = val[6:0];
			REG_IN_WIDTH:   cfg.width  = val[6:0];
			REG_PAD_TOP:    cfg.top    = val[6:0];
			REG_PAD_BOTTOM: cfg.bottom = val[6:0];
			REG_PAD_LEFT:   cfg.left   = val[6:0];
			REG_PAD_RIGHT:  cfg.right  = val[6:0];
			REG_PAD_MODE:   cfg.mode   = val[1:0];
			default:        cfg.fill   = val;
		endcase
	endtask

	task automatic program_regs(input pad_cfg_t c);
		wait_idle();
		write_reg(REG_IN_HEIGHT,  32'(c.height));
		write_reg(REG_IN_WIDTH,   32'(c.width));
		write_reg(REG_PAD_TOP,    32'(c.top));
		write_reg(REG_PAD_BOTTOM, 32'(c.bottom));
		write_reg(REG_PAD_LEFT,   32'(c.left));
		write_reg(REG_PAD_RIGHT,  32'(c.right));
		write_reg(REG_PAD_MODE,   32'(c.mode));
		write_reg(REG_FILL_WORD,  c.fill);
	endtask

	// one random setting followed by a batch of beats under it
	task automatic random_phase();
		pad_cfg_t c;
		int kind, pick, h, w, kh, kw, oh, ow, n, rmax, cmax;
		kind = $urandom_range(0, 11);
		h = draw_size();
		w = draw_size();
		pick = $urandom_range(0, 7);
		c = mk_cfg(7'(h), 7'(w), '0, '0, '0, '0, MODE_CONST,
			(pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom);
		case (kind)
			0, 1, 2, 3, 4: begin
				c.mode   = (kind < 3) ? MODE_CONST : MODE_REPL;
				c.top    = 7'(draw_pad(MAX_PAD));
				c.bottom = 7'(draw_pad(MAX_PAD));
				c.left   = 7'(draw_pad(MAX_PAD));
				c.right  = 7'(draw_pad(MAX_PAD));
			end
			5, 6, 7: begin
				// reflect: pads kept below the plane size
				c.mode   = MODE_REFL;
				kh = (h - 1 < MAX_PAD) ? h - 1 : MAX_PAD;
				kw = (w - 1 < MAX_PAD) ? w - 1 : MAX_PAD;
				c.top    = 7'(draw_pad(kh));
				c.bottom = 7'(draw_pad(kh));
				c.left   = 7'(draw_pad(kw));
				c.right  = 7'(draw_pad(kw));
			end
			8, 9: begin
				// crop; tiny planes end up as an empty crop
				c.mode   = 2'($urandom_range(0, 2));
				kh = ((h - 1) / 2 < 1) ? 1 : (h - 1) / 2;
				kw = ((w - 1) / 2 < 1) ? 1 : (w - 1) / 2;
				c.top    = 7'(-$urandom_range(1, kh));
				c.bottom = 7'(-$urandom_range(1, kh));
				c.left   = 7'(-$urandom_range(1, kw));
				c.right  = 7'(-$urandom_range(1, kw));
			end
			10: begin
				pick = $urandom_range(0, 2);
				c.top    = 7'(draw_pad(MAX_PAD));
				c.bottom = 7'(draw_pad(MAX_PAD));
				c.left   = 7'(draw_pad(MAX_PAD));
				c.right  = 7'(draw_pad(MAX_PAD));
				if (pick == 0) begin
					c.mode = MODE_RSVD;
				end else if (pick == 1) begin
					// one side negative, the rest not
					c.mode = 2'($urandom_range(0, 2));
					case ($urandom_range(0, 3))
						0: c.top    = 7'(-$urandom_range(1, MAX_PAD));
						1: c.bottom = 7'(-$urandom_range(1, MAX_PAD));
						2: c.left   = 7'(-$urandom_range(1, MAX_PAD));
						default: c.right = 7'(-$urandom_range(1, MAX_PAD));
					endcase
				end else begin
					// reflect border at least as wide as the plane
					h = $urandom_range(1, MAX_PAD);
					c.height = 7'(h);
					c.mode   = MODE_REFL;
					c.top    = 7'($urandom_range(h, MAX_PAD));
				end
			end
			default: begin
				// register values beyond the legal range
				c.height = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
				c.width  = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
				c.mode   = 2'($urandom_range(0, 2));
				if ($urandom_range(0, 1) == 0) begin
					c.top    = 7'($urandom_range(33, 63));
					c.bottom = 7'($urandom_range(33, 63));
					c.left   = 7'($urandom_range(33, 63));
					c.right  = 7'($urandom_range(33, 63));
				end else begin
					c.height = 7'($urandom_range(65, 127));
					c.width  = 7'($urandom_range(65, 127));
					c.top    = 7'($urandom_range(64, 95));
					c.bottom = 7'(-$urandom_range(1, 10));
					c.left   = 7'($urandom_range(64, 95));
					c.right  = 7'(-$urandom_range(1, 10));
				end
			end
		endcase
		program_regs(c);

		h  = eff_size(cfg.height, MAX_HEIGHT);
		w  = eff_size(cfg.width, MAX_WIDTH);
		oh = h + sat_pad(cfg.top) + sat_pad(cfg.bottom);
		ow = w + sat_pad(cfg.left) + sat_pad(cfg.right);
		rmax = (oh > 128) ? 127 : oh - 1;
		cmax = (ow > 128) ? 127 : ow - 1;
		n = (kind == 10) ? 30 : 150;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 3) begin
				if ($urandom_range(0, 6) == 0)
					put_load($urandom_range(0, 127), $urandom_range(0, 127), $urandom);
				else
					put_load($urandom_range(0, h - 1), $urandom_range(0, w - 1), $urandom);
			end else if (rmax >= 0 && cmax >= 0 && $urandom_range(0, 4) != 0) begin
				put_read($urandom_range(0, rmax), $urandom_range(0, cmax));
			end else begin
				put_read($urandom_range(0, 127), $urandom_range(0, 127));
			end
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sender: bursts of beats with gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			burst_left   <= 0;
			gap_left     <= 0;
		end else if (!req_if.valid || req_if.ready) begin
			if (gap_left != 0) begin
				req_if.valid <= 1'b0;
				gap_left     <= gap_left - 1;
			end else if (cmd_backlog.size() != 0) begin
				next_beat = cmd_backlog.pop_front();
				req_if.valid    <= 1'b1;
				req_if.command  <= next_beat.command;
				req_if.row      <= next_beat.row;
				req_if.col      <= next_beat.col;
				req_if.pixel_in <= next_beat.pixel;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// receiver: stall style is redrawn whenever its run counter expires
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			rx_style     <= RX_FREE;
			rx_left      <= 0;
		end else begin
			if (rx_left == 0) begin
				rx_style <= rx_style_t'($urandom_range(0, 3));
				rx_left  <= $urandom_range(64, 512);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_style)
				RX_FREE:   rsp_if.ready <= 1'b1;
				RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: rsp_if.ready <= (cycle_count[1:0] == 2'b00);
				default:   rsp_if.ready <= ($urandom_range(0, 19) == 0) ? ~rsp_if.ready
					: rsp_if.ready;
			endcase
		end
	end

	// monitor: predict on accepted commands, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				if (req_if.command == CMD_LOAD) begin
					if (int'(req_if.row) < eff_size(cfg.height, MAX_HEIGHT)
							&& int'(req_if.col) < eff_size(cfg.width, MAX_WIDTH))
						plane_img[int'(req_if.row) * MAX_WIDTH + int'(req_if.col)] = req_if.pixel_in;
				end else begin
					pad_lookup(int'(req_if.row), int'(req_if.col), seen_status,
						seen_from_store, seen_idx);
					want.status = seen_status;
					if (seen_status != ST_OK)
						want.pixel = '0;
					else if (seen_from_store)
						want.pixel = plane_img[seen_idx];
					else
						want.pixel = cfg.fill;
					padded_pixels.push_back(want);
				end
			end
			if (rsp_if.valid && rsp_if.ready) begin
				if (padded_pixels.size() == 0) begin
					flag_error($sformatf("result beat with none pending: pixel %08h status %0d",
						rsp_if.pixel_out, rsp_if.status));
				end else begin
					oldest = padded_pixels.pop_front();
					if (rsp_if.pixel_out !== oldest.pixel || rsp_if.status !== oldest.status)
						flag_error($sformatf(
							"result mismatch: expected pixel %08h status %0d, got pixel %08h status %0d",
							oldest.pixel, oldest.status, rsp_if.pixel_out, rsp_if.status));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("plane_border_pad regression: fail");
			$finish;
		end
	end

	// stimulus
	initial begin
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		req_if.valid    = 1'b0;
		req_if.command  = CMD_LOAD;
		req_if.row      = '0;
		req_if.col      = '0;
		req_if.pixel_in = '0;
		rsp_if.ready    = 1'b0;
		fault_count     = 0;
		counted_items   = 0;
		cycle_count     = 0;
		cfg = mk_cfg(7'd1, 7'd1, '0, '0, '0, '0, MODE_CONST, '0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: 1x1 plane, no border
		put_load(0, 0, 32'hFFFF_FFFF);
		put_load(1, 1, 32'h5A5A_5A5A);
		put_read(0, 0);
		put_read(0, 1);
		put_read(127, 127);

		// constant border at full size and full pad
		program_regs(mk_cfg(7'd64, 7'd64, 7'd32, 7'd32, 7'd32, 7'd32, MODE_CONST,
			32'h8000_0001));
		put_read(0, 0);
		put_read(127, 127);
		put_read(32, 32);
		put_read(63, 95);
		put_load(63, 63, 32'h0);
		put_read(95, 95);

		// replicate with sizes and pads beyond their range
		program_regs(mk_cfg(7'd0, 7'd127, 7'd33, 7'd63, 7'd50, 7'd0, MODE_REPL,
			32'hFFFF_FFFF));
		put_read(0, 0);
		put_read(64, 95);
		put_read(65, 0);

		// reflect with the widest legal border
		program_regs(mk_cfg(7'd33, 7'd33, 7'd32, 7'd32, 7'd32, 7'd32, MODE_REFL, '0));
		put_read(0, 0);
		put_read(96, 96);

		// reflect border as wide as the plane
		program_regs(mk_cfg(7'd32, 7'd40, 7'd32, 7'd0, 7'd0, 7'd0, MODE_REFL, '0));
		put_read(0, 0);

		// crop with a saturated negative pad, mode has no effect
		program_regs(mk_cfg(7'd100, 7'd64, 7'h40, 7'h7F, 7'h7B, 7'h7F, MODE_REFL,
			32'h1234_5678));
		put_read(0, 0);
		put_read(30, 57);
		put_read(31, 0);
		put_read(0, 58);

		// crop that leaves nothing
		program_regs(mk_cfg(7'd4, 7'd4, 7'h7E, 7'h7E, 7'h7F, 7'h7F, MODE_CONST, '0));
		put_read(0, 0);

		// one negative pad among positive ones
		program_regs(mk_cfg(7'd8, 7'd8, 7'h7F, 7'd1, 7'd1, 7'd1, MODE_CONST, '0));
		put_read(1, 1);

		// reserved mode
		program_regs(mk_cfg(7'd8, 7'd8, 7'd0, 7'd0, 7'd0, 7'd0, MODE_RSVD, '0));
		put_load(2, 2, $urandom);
		put_read(0, 0);

		counted_items = 0;
		while (counted_items < RANDOM_ITEMS)
			random_phase();

		wait_idle();
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("plane_border_pad regression: pass");
		else
			$display("plane_border_pad regression: fail");
		$finish;
	end

endmodule
